### rtl/motor_speed_integral_controller_defines.svh
// assertion macros for the motor speed integral controller
`ifndef MOTOR_SPEED_INTEGRAL_CONTROLLER_DEFINES_SVH
`define MOTOR_SPEED_INTEGRAL_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on the block clock, held off during reset
`define MSIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check a property on the block clock at every edge, reset included
`define MSIC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MSIC_ASSERT(label, prop, msg)
`define MSIC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### rtl/msic_pkg.sv
// types and constants of the motor speed integral controller
package msic_pkg;

    // field widths
    localparam int unsigned ActionW  = 2;
    localparam int unsigned SpeedW   = 17;
    localparam int unsigned DutyW    = 16;
    localparam int unsigned SetW     = 16;
    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 32;
    localparam int unsigned CfgIdxW  = 1;

    // setpoint steps in thousandths rps
    localparam logic [SetW-1:0] SetpointReset = 16'd20000;
    localparam logic [SetW-1:0] SetpointStep  = 16'd5000;
    localparam logic [SetW-1:0] SetpointMin   = 16'd10000;
    localparam logic [SetW-1:0] SetpointTop   = 16'd55000;
    localparam logic [SetW-1:0] SetpointMax   = 16'd60000;

    // duty limit reset values
    localparam logic [DutyW-1:0] FloorReset   = 16'd40;
    localparam logic [DutyW-1:0] CeilingReset = 16'd39960;

    // input action codes
    typedef enum logic [ActionW-1:0] {
        ACT_UPDATE   = 2'd0,
        ACT_INCREASE = 2'd1,
        ACT_DECREASE = 2'd2,
        ACT_OFF      = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DUTY_FLOOR   = 1'b0,
        CFG_DUTY_CEILING = 1'b1
    } t_cfg_index;

endpackage

### rtl/motor_speed_integral_controller.sv
// integral speed controller: stepped setpoint and clamped duty integrator
//
// Usage: each transfer on the s_axis channel carries one command (update with
// a measured speed, setpoint up, setpoint down, motor off) and produces
// exactly one result transfer on the m_axis channel with the duty count, a
// write strobe for the PWM (tuser) and the setpoint after the command.
// The command is registered on acceptance and evaluated from the input
// register; once the result register is free, the setpoint and integrator
// update and the result register loads.
// One command is taken per cycle while the receiver keeps up; the single
// evaluation stage between the input and result registers sets that rate.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more command; after that s_axis_tready
// drops until the result is taken.
// The cfg channel writes duty_floor (index 0) and duty_ceiling (index 1) and is
// always ready; the user must write it only while the block is idle (not enforced).
// Synchronous active-low reset empties both registers, sets the setpoint to
// 20000, the integrator to 0 and the limits to 40 and 39960.
`include "motor_speed_integral_controller_defines.svh"

module motor_speed_integral_controller
    import msic_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // [1:0] action, [18:2] measured_speed
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // [15:0] duty_count, [31:16] target_speed
    output logic                m_axis_tuser,   // [0] duty_write
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [DutyW-1:0]    i_cfg_data
);

    // input register
    logic              r_in_valid;
    t_action           r_in_action;
    logic [SpeedW-1:0] r_in_speed;

    // state and limits
    logic [SetW-1:0]  r_setpoint;
    logic [DutyW-1:0] r_duty;
    logic [DutyW-1:0] r_floor;
    logic [DutyW-1:0] r_ceiling;

    // result register
    logic             r_out_valid;
    logic [DutyW-1:0] r_out_duty;
    logic             r_out_write;
    logic [SetW-1:0]  r_out_set;

    // evaluation stage
    logic                w_accept;
    logic                w_out_free;
    logic                w_adv;
    logic signed [17:0]  w_err;
    logic signed [19:0]  w_prod;
    logic signed [19:0]  w_prod_adj;
    logic signed [13:0]  w_quot;
    logic signed [17:0]  w_sum;
    logic [DutyW-1:0]    w_clamped;
    logic [SetW-1:0]     n_setpoint;
    logic [DutyW-1:0]    n_duty;
    logic [DutyW-1:0]    n_out_duty;
    logic                n_out_write;

    // handshake
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // error, gain of 3/64 truncated toward zero, integrator sum
    assign w_err      = $signed({2'b00, r_setpoint}) - $signed({1'b0, r_in_speed});
    assign w_prod     = ({{2{w_err[17]}}, w_err} <<< 1) + {{2{w_err[17]}}, w_err};
    assign w_prod_adj = w_prod + (w_prod[19] ? 20'sd63 : 20'sd0);
    assign w_quot     = w_prod_adj[19:6];
    assign w_sum      = $signed({2'b00, r_duty}) + {{4{w_quot[13]}}, w_quot};

    // clamp, floor first
    always_comb begin
        if (w_sum < $signed({2'b00, r_floor})) begin
            w_clamped = r_floor;
        end else if (w_sum > $signed({2'b00, r_ceiling})) begin
            w_clamped = r_ceiling;
        end else begin
            w_clamped = w_sum[DutyW-1:0];
        end
    end

    // command decode
    always_comb begin
        n_setpoint  = r_setpoint;
        n_duty      = r_duty;
        n_out_duty  = '0;
        n_out_write = 1'b0;
        unique case (r_in_action)
            ACT_UPDATE: begin
                n_duty      = (r_setpoint == '0) ? '0 : w_clamped;
                n_out_duty  = n_duty;
                n_out_write = 1'b1;
            end
            ACT_INCREASE: begin
                if (r_setpoint == '0) begin
                    n_setpoint = SetpointMin;
                end else if (r_setpoint <= SetpointTop) begin
                    n_setpoint = r_setpoint + SetpointStep;
                end
            end
            ACT_DECREASE: begin
                if (r_setpoint > SetpointMin) begin
                    n_setpoint = r_setpoint - SetpointStep;
                end else if (r_setpoint == SetpointMin) begin
                    n_setpoint = '0;
                end
            end
            ACT_OFF: begin
                n_out_write = 1'b1;
            end
            default: begin
                n_out_write = 1'b0;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (w_accept) begin
            r_in_action <= t_action'(s_axis_tdata[ActionW-1:0]);
            r_in_speed  <= s_axis_tdata[ActionW+SpeedW-1:ActionW];
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= SetpointReset;
            r_duty     <= '0;
        end else if (w_adv) begin
            r_setpoint <= n_setpoint;
            r_duty     <= n_duty;
        end
    end

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= FloorReset;
            r_ceiling <= CeilingReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DUTY_FLOOR:   r_floor   <= i_cfg_data;
                CFG_DUTY_CEILING: r_ceiling <= i_cfg_data;
                default:          r_floor   <= r_floor;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_out_duty  <= n_out_duty;
            r_out_write <= n_out_write;
            r_out_set   <= n_setpoint;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_set, r_out_duty};
    assign m_axis_tuser  = r_out_write;

    // checks
    `MSIC_ASSERT(a_setpoint_legal,
        (r_setpoint == '0) || ((r_setpoint >= SetpointMin) && (r_setpoint <= SetpointMax)),
        "setpoint left its legal range")
    `MSIC_ASSERT(a_nowrite_zero_duty,
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[DutyW-1:0] == '0),
        "setpoint change result carries a nonzero duty")
    `MSIC_ASSERT(a_stopped_update_zero,
        (w_adv && (r_in_action == ACT_UPDATE) && (r_setpoint == '0)) |=>
            ((r_out_duty == '0) && (r_duty == '0)),
        "update at stopped setpoint did not force zero duty")
    `MSIC_ASSERT(a_full_stall_blocks,
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready,
        "command taken while both registers are held")
    `MSIC_ASSERT_ALWAYS(a_cfg_always_ready, o_cfg_ready,
        "configuration channel not ready")

endmodule
